[sv/bcdm_pkg.sv]
// Shared types, constants and the six-step sector table for the commutation mapper.
`default_nettype none

package bcdm_pkg;

  localparam int NUM_LANES = 3;
  localparam int DUTY_W    = 16;
  localparam int CMP_W     = 16;
  localparam int MODE_W    = 2;
  localparam int SECTOR_W  = 3;
  localparam int PERIOD_W  = 16;
  localparam int PROD_W    = (DUTY_W - 1) + PERIOD_W;

  // in_tdata: duty_ch1, duty_ch2, duty_ch3, sector, sector_duty (67 bits, padded)
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 1;
  // out_tdata: compare_ch1..3, mode_ph1..3, modes_changed (55 bits, padded)
  localparam int OUT_DATA_W = 56;

  localparam int SECTOR_LSB = NUM_LANES * DUTY_W;
  localparam int SDUTY_LSB  = SECTOR_LSB + SECTOR_W;
  localparam int MODES_LSB  = NUM_LANES * CMP_W;
  localparam int CHG_BIT    = MODES_LSB + NUM_LANES * MODE_W;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_FLOAT = 2'd0;
  localparam mode_t MODE_CPWM  = 2'd1;
  localparam mode_t MODE_HPWM  = 2'd2;
  localparam mode_t MODE_LOW   = 2'd3;

  localparam logic FUNC_DUTY = 1'b0;
  localparam logic FUNC_SIX  = 1'b1;

  localparam logic CFG_IDX_PERIOD = 1'b0;
  localparam logic CFG_IDX_PB_DIS = 1'b1;

  // One lane's registered result.
  typedef struct packed {
    mode_t             mode;
    logic [CMP_W-1:0]  cmp;
  } lane_res_t;

  // Mode of phase 'lane' (0..2) in six-step sector 's'; sectors six and seven float.
  function automatic mode_t sector_mode(input logic [SECTOR_W-1:0] s,
                                        input logic [1:0] lane);
    mode_t m1;
    mode_t m2;
    mode_t m3;
    m1 = MODE_FLOAT;
    m2 = MODE_FLOAT;
    m3 = MODE_FLOAT;
    unique case (s)
      3'd0: begin m1 = MODE_LOW;   m2 = MODE_FLOAT; m3 = MODE_HPWM;  end
      3'd1: begin m1 = MODE_LOW;   m2 = MODE_HPWM;  m3 = MODE_FLOAT; end
      3'd2: begin m1 = MODE_FLOAT; m2 = MODE_HPWM;  m3 = MODE_LOW;   end
      3'd3: begin m1 = MODE_HPWM;  m2 = MODE_FLOAT; m3 = MODE_LOW;   end
      3'd4: begin m1 = MODE_HPWM;  m2 = MODE_LOW;   m3 = MODE_FLOAT; end
      3'd5: begin m1 = MODE_FLOAT; m2 = MODE_LOW;   m3 = MODE_HPWM;  end
      default: begin m1 = MODE_FLOAT; m2 = MODE_FLOAT; m3 = MODE_FLOAT; end
    endcase
    unique case (lane)
      2'd0:    return m1;
      2'd1:    return m2;
      2'd2:    return m3;
      default: return MODE_FLOAT;
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/bcdm_lane.sv]
// One phase lane: decode pin mode, pick the duty and scale it by the timer period.
`default_nettype none

module bcdm_lane (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic                            func,
  input  wire logic [bcdm_pkg::SECTOR_W-1:0]   sector,
  input  wire logic [1:0]                      lane_id,
  input  wire logic signed [bcdm_pkg::DUTY_W-1:0] duty,
  input  wire logic signed [bcdm_pkg::DUTY_W-1:0] sector_duty,
  input  wire logic                            forced_float,
  input  wire logic [bcdm_pkg::PERIOD_W-1:0]   period,
  output bcdm_pkg::lane_res_t                  res
);
  import bcdm_pkg::*;

  mode_t                mode_nxt;
  logic [DUTY_W-2:0]    duty_sel;
  logic [PROD_W-1:0]    prod;
  lane_res_t            res_r;

  // Decode mode and the magnitude that drives this phase's compare
  always_comb begin
    mode_nxt = MODE_FLOAT;
    duty_sel = '0;
    if (func == FUNC_DUTY) begin
      if (!duty[DUTY_W-1] && !forced_float) begin
        mode_nxt = MODE_CPWM;
        duty_sel = duty[DUTY_W-2:0];
      end
    end else begin
      mode_nxt = sector_mode(sector, lane_id);
      if (mode_nxt == MODE_HPWM && !sector_duty[DUTY_W-1]) begin
        duty_sel = sector_duty[DUTY_W-2:0];
      end
    end
  end

  // Scale: compare = (duty * period) >> 15
  assign prod = PROD_W'(duty_sel) * PROD_W'(period);

  // Hold the lane result when stalled
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.mode <= mode_nxt;
      res_r.cmp  <= prod[PROD_W-1 -: CMP_W];
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[sv/bcdm_merge.sv]
// Merge stage: pack lane results, flag a mode change and hold the output item.
`default_nettype none

module bcdm_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire bcdm_pkg::lane_res_t [bcdm_pkg::NUM_LANES-1:0] lanes,
  output logic [bcdm_pkg::OUT_DATA_W-1:0]           out_data
);
  import bcdm_pkg::*;

  logic [NUM_LANES*MODE_W-1:0] modes_packed;
  logic [NUM_LANES*CMP_W-1:0]  cmps_packed;
  logic                        changed;
  logic [NUM_LANES*MODE_W-1:0] phase_modes_r;
  logic [OUT_DATA_W-1:0]       out_data_r;

  // Gather modes and compares, phase 1 lowest
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      modes_packed[i*MODE_W +: MODE_W] = lanes[i].mode;
      cmps_packed[i*CMP_W +: CMP_W]    = lanes[i].cmp;
    end
    changed = (modes_packed != phase_modes_r);
  end

  // Track the modes of the last item; reset leaves all phases floating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_modes_r <= '0;
    end else if (en) begin
      phase_modes_r <= modes_packed;
    end
  end

  // Load the output item
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_DATA_W'({changed, modes_packed, cmps_packed});
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

[sv/bridge_commutation_duty_mapper_core.sv]
// Top level: three-phase duty / six-step commutation mapper with stream ports.
// From input accept to result valid: lane stage, then merge stage, both registered.
// One item per cycle unless output stalls; one 15x16 multiplier lane per phase.
// A waiting result does not block input: the lane stage fills while output stalls.
// Reset (rst_n low, synchronous): drops both stages, clears the PWM period and
// the phase B disable bit, and returns the held phase modes to all floating.
`default_nettype none

module bridge_commutation_duty_mapper_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input item
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [15:0] duty_ch1, [31:16] duty_ch2, [47:32] duty_ch3, [50:48] sector,
  // [66:51] sector_duty, [71:67] zero
  input  wire logic [bcdm_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] func
  input  wire logic [bcdm_pkg::IN_USER_W-1:0]    in_tuser,
  // result item
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] compare_ch1, [31:16] compare_ch2, [47:32] compare_ch3,
  // [49:48] mode_ph1, [51:50] mode_ph2, [53:52] mode_ph3, [54] modes_changed, [55] zero
  output logic [bcdm_pkg::OUT_DATA_W-1:0]        out_tdata,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [bcdm_pkg::PERIOD_W-1:0]     cfg_data
);
  import bcdm_pkg::*;

  logic                            s1_v_r;
  logic                            s1_v_nxt;
  logic                            out_v_r;
  logic                            out_v_nxt;
  logic                            adv_in;
  logic                            adv_out;
  logic [PERIOD_W-1:0]             period_r;
  logic                            pb_dis_r;
  lane_res_t [NUM_LANES-1:0]       lane_res;

  // Pipeline flow control
  assign adv_out   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv_out;
  assign adv_in    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt  = in_tready ? in_tvalid : s1_v_r;
    out_v_nxt = adv_out ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      pb_dis_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_PERIOD: period_r <= cfg_data;
        CFG_IDX_PB_DIS: pb_dis_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One lane per phase
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bcdm_lane u_lane (
      .clk          (clk),
      .en           (adv_in),
      .func         (in_tuser[0]),
      .sector       (in_tdata[SECTOR_LSB +: SECTOR_W]),
      .lane_id      (2'(g)),
      .duty         (in_tdata[g*DUTY_W +: DUTY_W]),
      .sector_duty  (in_tdata[SDUTY_LSB +: DUTY_W]),
      .forced_float ((g == 1) && pb_dis_r),
      .period       (period_r),
      .res          (lane_res[g])
    );
  end

  bcdm_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_v_r && adv_out),
    .lanes    (lane_res),
    .out_data (out_tdata)
  );

  assign out_tvalid = out_v_r;

endmodule

`default_nettype wire

[sv/bcdm_checker.sv]
// Port-level checks on the commutation mapper, bound to the top level.
`default_nettype none

module bcdm_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [bcdm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bcdm_pkg::*;

  mode_t m1;
  mode_t m2;
  mode_t m3;

  assign m1 = out_tdata[MODES_LSB +: MODE_W];
  assign m2 = out_tdata[MODES_LSB + MODE_W +: MODE_W];
  assign m3 = out_tdata[MODES_LSB + 2*MODE_W +: MODE_W];

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An unpowered phase 1 carries no compare
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (m1 == MODE_FLOAT || m1 == MODE_LOW) |->
      out_tdata[CMP_W-1:0] == '0)
    else $error("compare_ch1 nonzero on idle phase");

  // With phase 1 on high-side PWM, no other phase drives high-side PWM
  a_one_hpwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && m1 == MODE_HPWM |-> m2 != MODE_HPWM && m3 != MODE_HPWM)
    else $error("more than one high-side PWM phase");

  // Six-step and duty modes never mix in one item
  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (m1 == MODE_CPWM || m2 == MODE_CPWM || m3 == MODE_CPWM) |->
      m1 != MODE_HPWM && m2 != MODE_HPWM && m3 != MODE_HPWM &&
      m1 != MODE_LOW && m2 != MODE_LOW && m3 != MODE_LOW)
    else $error("duty and six-step modes mixed");

endmodule

bind bridge_commutation_duty_mapper_core bcdm_checker u_bcdm_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the three-phase duty / six-step commutation mapper.
`timescale 1ns / 100ps

module tb;
  import bcdm_pkg::*;

  // One command as it travels on the input stream.
  typedef struct packed {
    logic        func;
    logic [15:0] duty1;
    logic [15:0] duty2;
    logic [15:0] duty3;
    logic [2:0]  sector;
    logic [15:0] sector_duty;
  } bridge_cmd_t;

  // One result as it travels on the output stream.
  typedef struct packed {
    logic [15:0] cmp1;
    logic [15:0] cmp2;
    logic [15:0] cmp3;
    mode_t       mode1;
    mode_t       mode2;
    mode_t       mode3;
    logic        changed;
  } bridge_res_t;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [PERIOD_W-1:0]   cfg_data = '0;

  // Predictor copy of the registers and the held phase modes.
  logic [15:0] period_reg = '0;
  logic        pb_off_reg = 1'b0;
  logic [5:0]  held_modes = '0;

  bridge_cmd_t pending_cmd_q[$];
  bridge_res_t expected_res_q[$];

  int cmd_issued = 0;
  int cmd_taken  = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int gap_max    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  int hold_left  = 0;
  bit failed     = 1'b0;

  bridge_commutation_duty_mapper_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q1.15 duty times period, truncated; only called for non-negative duties.
  function automatic logic [15:0] scale_q15(input logic [15:0] duty);
    logic [30:0] prod;
    prod = duty[14:0] * period_reg;
    return prod[30:15];
  endfunction

  // Work out the result of one command and advance the held modes.
  function automatic bridge_res_t predict_bridge(input bridge_cmd_t c);
    bridge_res_t r;
    logic [15:0] duty [3];
    logic [15:0] cmp [3];
    mode_t       md [3];
    logic [5:0]  modes_now;
    int          pwm_lane;
    cmp = '{16'd0, 16'd0, 16'd0};
    md = '{MODE_FLOAT, MODE_FLOAT, MODE_FLOAT};
    duty = '{c.duty1, c.duty2, c.duty3};
    pwm_lane = -1;
    if (c.func == FUNC_DUTY) begin
      for (int k = 0; k < 3; k++) begin
        if (!duty[k][15] && !(k == 1 && pb_off_reg)) begin
          md[k] = MODE_CPWM;
          cmp[k] = scale_q15(duty[k]);
        end
      end
    end else begin
      case (c.sector)
        3'd0: begin md = '{MODE_LOW, MODE_FLOAT, MODE_HPWM}; pwm_lane = 2; end
        3'd1: begin md = '{MODE_LOW, MODE_HPWM, MODE_FLOAT}; pwm_lane = 1; end
        3'd2: begin md = '{MODE_FLOAT, MODE_HPWM, MODE_LOW}; pwm_lane = 1; end
        3'd3: begin md = '{MODE_HPWM, MODE_FLOAT, MODE_LOW}; pwm_lane = 0; end
        3'd4: begin md = '{MODE_HPWM, MODE_LOW, MODE_FLOAT}; pwm_lane = 0; end
        3'd5: begin md = '{MODE_FLOAT, MODE_LOW, MODE_HPWM}; pwm_lane = 2; end
        default: pwm_lane = -1;
      endcase
      // Negative sector duty clamps to zero.
      if (pwm_lane >= 0 && !c.sector_duty[15])
        cmp[pwm_lane] = scale_q15(c.sector_duty);
    end
    modes_now = {md[2], md[1], md[0]};
    r.cmp1 = cmp[0];
    r.cmp2 = cmp[1];
    r.cmp3 = cmp[2];
    r.mode1 = md[0];
    r.mode2 = md[1];
    r.mode3 = md[2];
    r.changed = (modes_now != held_modes);
    held_modes = modes_now;
    return r;
  endfunction

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  // Drive items at the falling edge: hold until taken, then bursts and gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && cmd_taken != cmd_issued) begin
      // hold the current item
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (pending_cmd_q.size() == 0) begin
      in_tvalid <= 1'b0;
    end else begin
      bridge_cmd_t c;
      c = pending_cmd_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {5'b0, c.sector_duty, c.sector, c.duty3, c.duty2, c.duty1};
      in_tuser <= c.func;
      cmd_issued++;
      if (burst_left > 0)
        burst_left--;
      if (burst_left == 0 && gap_max > 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = $urandom_range(1, gap_max);
      end
    end
  end

  // Receiver: long hold-off on request, else short random stall runs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check results and record accepted items at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_res_q.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result: expected none actual %h", $time, out_tdata);
        end else begin
          bridge_res_t want;
          want = expected_res_q.pop_front();
          compare_field("compare_ch1", want.cmp1, out_tdata[15:0]);
          compare_field("compare_ch2", want.cmp2, out_tdata[31:16]);
          compare_field("compare_ch3", want.cmp3, out_tdata[47:32]);
          compare_field("mode_ph1", want.mode1, out_tdata[49:48]);
          compare_field("mode_ph2", want.mode2, out_tdata[51:50]);
          compare_field("mode_ph3", want.mode3, out_tdata[53:52]);
          compare_field("modes_changed", want.changed, out_tdata[54]);
        end
      end
      if (in_tvalid && in_tready) begin
        bridge_cmd_t c;
        c.func = in_tuser[0];
        c.duty1 = in_tdata[15:0];
        c.duty2 = in_tdata[31:16];
        c.duty3 = in_tdata[47:32];
        c.sector = in_tdata[50:48];
        c.sector_duty = in_tdata[66:51];
        cmd_taken++;
        expected_res_q.push_back(predict_bridge(c));
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_PERIOD: period_reg = val;
      CFG_IDX_PB_DIS: pb_off_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued item is taken and every result is back, then settle.
  task automatic wait_idle();
    int waited;
    waited = 0;
    do @(negedge clk); while (pending_cmd_q.size() != 0 || cmd_taken != cmd_issued);
    while (expected_res_q.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (expected_res_q.size() != 0) begin
      failed = 1'b1;
      $display("%0t: missing results: expected %0d more actual 0",
               $time, expected_res_q.size());
      expected_res_q.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int gaps, input int stalls);
    @(posedge clk);
    gap_max = gaps;
    stall_pct = stalls;
    burst_left = 0;
  endtask

  task automatic queue_cmd(input logic func, input logic [15:0] d1, input logic [15:0] d2,
                           input logic [15:0] d3, input logic [2:0] sec,
                           input logic [15:0] sd);
    pending_cmd_q.push_back('{func, d1, d2, d3, sec, sd});
  endtask

  function automatic logic [15:0] pick_duty();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bridge_cmd_t random_cmd();
    bridge_cmd_t c;
    c.func = ($urandom_range(0, 1) == 1) ? FUNC_SIX : FUNC_DUTY;
    c.duty1 = pick_duty();
    c.duty2 = pick_duty();
    c.duty3 = pick_duty();
    c.sector = 3'($urandom_range(0, 7));
    c.sector_duty = pick_duty();
    return c;
  endfunction

  initial begin
    logic [15:0] period_set [7];
    bridge_cmd_t c;
    bridge_cmd_t last_cmd;
    period_set = '{16'hFFFF, 16'h0001, 16'($urandom), 16'h8000, 16'($urandom),
                   16'h0000, 16'($urandom)};
    last_cmd = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: full period, all channels enabled.
    write_reg(CFG_IDX_PERIOD, 16'hFFFF);
    write_reg(CFG_IDX_PB_DIS, 16'h0000);
    set_idling(0, 0);
    queue_cmd(FUNC_DUTY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h0000);
    queue_cmd(FUNC_DUTY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h0000);
    queue_cmd(FUNC_DUTY, 16'h0000, 16'h0000, 16'h0000, 3'd7, 16'hFFFF);
    queue_cmd(FUNC_DUTY, 16'h8000, 16'hFFFF, 16'h8000, 3'd5, 16'h7FFF);
    queue_cmd(FUNC_DUTY, 16'h7FFF, 16'h8000, 16'h0001, 3'd2, 16'h8000);
    queue_cmd(FUNC_SIX, 16'h1234, 16'h8000, 16'hFFFF, 3'd0, 16'h7FFF);
    for (int s = 1; s < 6; s++)
      queue_cmd(FUNC_SIX, 16'hFFFF, 16'h7FFF, 16'h8000, 3'(s), 16'h7FFF);
    queue_cmd(FUNC_SIX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd6, 16'h7FFF);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd7, 16'h4000);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd7, 16'h4000);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd3, 16'h8000);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd3, 16'hFFFF);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd2, 16'h0000);
    queue_cmd(FUNC_DUTY, 16'hFFFF, 16'h7FFF, 16'hFFFF, 3'd1, 16'h1111);
    wait_idle();

    // Directed: phase B disabled, half period.
    write_reg(CFG_IDX_PERIOD, 16'h7FFF);
    write_reg(CFG_IDX_PB_DIS, 16'h0001);
    set_idling(3, 20);
    queue_cmd(FUNC_DUTY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h0000);
    queue_cmd(FUNC_DUTY, 16'h0000, 16'h8000, 16'h0000, 3'd0, 16'h0000);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd1, 16'h7FFF);
    queue_cmd(FUNC_SIX, 16'h0000, 16'h0000, 16'h0000, 3'd4, 16'h2AAA);
    queue_cmd(FUNC_DUTY, 16'h0001, 16'h0001, 16'h0001, 3'd6, 16'h0001);
    wait_idle();

    // Random phases over a spread of periods; phase two holds off the receiver.
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_IDX_PERIOD, period_set[p]);
      write_reg(CFG_IDX_PB_DIS, (p % 3 == 1) ? 16'h0001 : 16'h0000);
      case (p)
        2: set_idling(0, 10);
        4: set_idling(0, 0);
        default: set_idling($urandom_range(2, 10), $urandom_range(10, 60));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n > 0 && $urandom_range(0, 7) == 0)
          c = last_cmd;
        else
          c = random_cmd();
        pending_cmd_q.push_back(c);
        last_cmd = c;
      end
      if (p == 2)
        hold_req++;
      wait_idle();
    end

    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[bridge_commutation_duty_mapper_core.f]
sv/bcdm_pkg.sv
sv/bcdm_lane.sv
sv/bcdm_merge.sv
sv/bridge_commutation_duty_mapper_core.sv
sv/bcdm_checker.sv
tb/tb.sv
